### sv/step_sequencer_slide_accent_macros.svh
// assertion macros for the step sequencer
// expects clk and rst_n in the scope of use
`ifndef STEP_SEQUENCER_SLIDE_ACCENT_MACROS_SVH
`define STEP_SEQUENCER_SLIDE_ACCENT_MACROS_SVH

// same-cycle implication
`define SQSA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SQSA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sqsa_pkg.sv
// shared types and constants for the step sequencer
// no dependencies
`timescale 1ns / 1ps

package sqsa_pkg;

    localparam int MAX_STEPS_DEF = 16;
    localparam int Q_DEPTH_DEF   = 2;

    localparam int MODE_W    = 2;
    localparam int STEP_W    = 4;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 9;
    localparam int KIND_W    = 2;
    localparam int ENTRY_W   = 10;
    localparam int SPS_W     = 32;
    localparam int CNT_REG_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SPS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

    localparam logic [SPS_W-1:0]     SPS_RESET   = 32'd1536000;
    localparam logic [CNT_REG_W-1:0] COUNT_RESET = 5'd16;
    localparam logic [SPS_W:0]       ONE_SAMPLE  = 33'd256;

    localparam logic [VEL_W-1:0] VEL_ACCENT = 9'd256;
    localparam logic [VEL_W-1:0] VEL_NORMAL = 9'd141;
    localparam logic [VEL_W-1:0] VEL_NONE   = 9'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ON      = 2'd0,
        KIND_OFF     = 2'd1,
        KIND_ALL_OFF = 2'd2
    } kind_t;

    // step table entry, note in the low bits
    typedef struct packed {
        logic              slide;
        logic              accent;
        logic              on;
        logic [NOTE_W-1:0] note;
    } entry_t;

    // word between front and back
    typedef struct packed {
        logic              clear;
        logic [STEP_W-1:0] step;
        logic [NOTE_W-1:0] note;
        logic              on;
        logic              accent;
        logic              prev_slide;
    } q_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic [STEP_W-1:0] step;
        logic              last;
    } evt_t;

endpackage

### sv/sqsa_if.sv
// channel interfaces for the step sequencer: command, event and config write
// depends on sqsa_pkg
`timescale 1ns / 1ps

interface sqsa_cmd_if import sqsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [STEP_W-1:0] step_index;
    logic [NOTE_W-1:0] step_note;
    logic              step_on;
    logic              step_accent;
    logic              step_slide;

    modport source (output valid, mode, step_index, step_note, step_on, step_accent,
                    step_slide, input ready);
    modport sink (input valid, mode, step_index, step_note, step_on, step_accent,
                  step_slide, output ready);
endinterface

interface sqsa_evt_if import sqsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  velocity_q8;
    logic [STEP_W-1:0] step_now;
    logic              last;

    modport source (output valid, event_kind, note_number, velocity_q8, step_now, last,
                    input ready);
    modport sink (input valid, event_kind, note_number, velocity_q8, step_now, last,
                  output ready);
endinterface

interface sqsa_cfg_if import sqsa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SPS_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### sv/sqsa_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sqsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/sqsa_front.sv
// front end: takes commands and config, keeps the playback position and the
// step table, and issues step changes and rewinds to the back end
// depends on sqsa_pkg, sqsa_if, sqsa_ram
`timescale 1ns / 1ps

module sqsa_front import sqsa_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    sqsa_cmd_if.sink cmd,
    sqsa_cfg_if.sink cfg,
    output logic    push_valid,
    input  logic    push_ready,
    output q_item_t push_item
);

    localparam int AW = $clog2(MAX_STEPS);
    localparam int CW = (AW + 1 > CNT_REG_W) ? AW + 1 : CNT_REG_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STEPS);

    logic [SPS_W-1:0]     sps_reg;
    logic [CNT_REG_W-1:0] count_reg;
    logic                 playing_reg, playing_next;
    logic                 known_reg, known_next;
    logic [AW-1:0]        cur_step_reg, cur_step_next;
    logic [SPS_W-1:0]     phase_reg, phase_next;
    logic                 cur_slide_reg, cur_slide_next;
    logic [MAX_STEPS-1:0] valid_reg, valid_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_clear_reg;
    logic [STEP_W-1:0]    s1_step_reg;
    logic                 s1_prev_reg;
    logic                 s1_vld_reg;

    logic          acc;
    logic          s1_move;
    logic          s1_load;
    logic          enter;
    logic          clear;
    logic [AW-1:0] enter_step;
    logic          prev_slide;
    logic          we;
    logic [AW-1:0] waddr;
    logic          idx_ok;
    logic [SPS_W:0] len;
    logic [SPS_W:0] p;
    logic [SPS_W:0] p_wrap;
    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] cnt_eff;
    logic [CW-1:0] nxt;
    logic [CW-1:0] nxt_w;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t        rd_entry;
    entry_t        wr_entry;

    assign cfg.ready  = 1'b1;
    assign cmd.ready  = !s1_valid_reg || push_ready;
    assign acc        = cmd.valid && cmd.ready;
    assign s1_move    = s1_valid_reg && push_ready;
    assign push_valid = s1_valid_reg;

    assign waddr  = AW'(cmd.step_index);
    assign idx_ok = CW'(cmd.step_index) < MAX_CNT;

    assign wr_entry = '{slide: cmd.step_slide, accent: cmd.step_accent,
                        on: cmd.step_on, note: cmd.step_note};
    assign rd_entry = entry_t'(ram_rdata);

    // step length below one sample acts as one sample
    assign len    = (sps_reg < ONE_SAMPLE[SPS_W-1:0]) ? ONE_SAMPLE : {1'b0, sps_reg};
    assign p      = {1'b0, phase_reg} + ONE_SAMPLE;
    assign p_wrap = p - len;

    assign cnt_ext = CW'(count_reg);
    assign cnt_eff = (cnt_ext == '0) ? CW'(1) : ((cnt_ext > MAX_CNT) ? MAX_CNT : cnt_ext);
    assign nxt     = CW'(cur_step_reg) + CW'(1);
    assign nxt_w   = (nxt >= cnt_eff) ? '0 : nxt;

    // slide of the step being left; its entry may still sit in the read stage
    assign prev_slide = known_reg &&
        ((s1_valid_reg && !s1_clear_reg) ? (rd_entry.slide && s1_vld_reg) : cur_slide_reg);

    always_comb
    begin
        playing_next  = playing_reg;
        known_next    = known_reg;
        cur_step_next = cur_step_reg;
        phase_next    = phase_reg;
        valid_next    = valid_reg;
        enter         = 1'b0;
        clear         = 1'b0;
        enter_step    = '0;
        we            = 1'b0;
        if (acc)
        begin
            case (mode_t'(cmd.mode))
                MODE_TICK:
                begin
                    if (playing_reg)
                    begin
                        if (!known_reg)
                        begin
                            phase_next = '0;
                            enter      = 1'b1;
                            enter_step = '0;
                        end
                        else if (p >= len)
                        begin
                            phase_next = p_wrap[SPS_W-1:0];
                            if (nxt_w != CW'(cur_step_reg))
                            begin
                                enter      = 1'b1;
                                enter_step = nxt_w[AW-1:0];
                            end
                        end
                        else
                        begin
                            phase_next = p[SPS_W-1:0];
                        end
                    end
                end
                MODE_WRITE:
                begin
                    if (idx_ok)
                    begin
                        we               = 1'b1;
                        valid_next[waddr] = 1'b1;
                    end
                end
                MODE_START:
                begin
                    playing_next = 1'b1;
                end
                MODE_STOP:
                begin
                    playing_next  = 1'b0;
                    known_next    = 1'b0;
                    cur_step_next = '0;
                    phase_next    = '0;
                    clear         = 1'b1;
                end
                default:
                begin
                    playing_next = playing_reg;
                end
            endcase
            if (enter)
            begin
                cur_step_next = enter_step;
                known_next    = 1'b1;
            end
        end
    end

    always_comb
    begin
        cur_slide_next = cur_slide_reg;
        if (s1_move && !s1_clear_reg)
        begin
            cur_slide_next = rd_entry.slide && s1_vld_reg;
        end
        // a later write to the current step overrides what was read
        if (we && (waddr == cur_step_reg))
        begin
            cur_slide_next = cmd.step_slide;
        end
    end

    assign s1_load       = acc && (enter || clear);
    assign s1_valid_next = s1_load ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);

    sqsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .re    (acc && enter),
        .raddr (enter_step),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sps_reg       <= SPS_RESET;
            count_reg     <= COUNT_RESET;
            playing_reg   <= 1'b0;
            known_reg     <= 1'b0;
            cur_step_reg  <= '0;
            phase_reg     <= '0;
            cur_slide_reg <= 1'b0;
            valid_reg     <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SPS:   sps_reg   <= cfg.data;
                    REG_COUNT: count_reg <= cfg.data[CNT_REG_W-1:0];
                    default:   sps_reg   <= sps_reg;
                endcase
            end
            playing_reg   <= playing_next;
            known_reg     <= known_next;
            cur_step_reg  <= cur_step_next;
            phase_reg     <= phase_next;
            cur_slide_reg <= cur_slide_next;
            valid_reg     <= valid_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_clear_reg <= clear;
            s1_step_reg  <= STEP_W'(enter_step);
            s1_prev_reg  <= prev_slide;
            s1_vld_reg   <= enter && valid_reg[enter_step];
        end
    end

    assign push_item.clear      = s1_clear_reg;
    assign push_item.step       = s1_step_reg;
    assign push_item.note       = rd_entry.note & {NOTE_W{s1_vld_reg}};
    assign push_item.on         = rd_entry.on && s1_vld_reg;
    assign push_item.accent     = rd_entry.accent && s1_vld_reg;
    assign push_item.prev_slide = s1_prev_reg;

endmodule

### sv/sqsa_queue.sv
// short fifo of words between front and back end
// depends on sqsa_pkg
`timescale 1ns / 1ps

module sqsa_queue import sqsa_pkg::*; #(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  q_item_t push_item,
    output logic    head_valid,
    output q_item_t head,
    input  logic    pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    q_item_t        mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg < NW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + NW'(do_push) - NW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/sqsa_back.sv
// back end: turns step changes into note events, tracks the sounding note,
// drives the event channel through an output register
// depends on sqsa_pkg, sqsa_if
`timescale 1ns / 1ps

module sqsa_back import sqsa_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  q_item_t     head,
    output logic        pop,
    sqsa_evt_if.source  evt
);

    logic              ev_idx_reg, ev_idx_next;
    logic              sounding_reg, sounding_next;
    logic [NOTE_W-1:0] snote_reg, snote_next;
    logic              out_valid_reg, out_valid_next;
    evt_t              out_reg;

    logic              slide_path;
    logic [1:0]        n_ev;
    logic [VEL_W-1:0]  vel;
    evt_t              ev_on;
    evt_t              ev_off;
    evt_t              ev_all;
    evt_t              ev_first;
    evt_t              ev_second;
    evt_t              ev_sel;
    logic              slot_free;
    logic              load;

    assign slide_path = head.prev_slide && sounding_reg;
    assign vel        = head.accent ? VEL_ACCENT : VEL_NORMAL;

    assign ev_on  = '{kind: KIND_ON, note: head.note, vel: vel, step: head.step, last: 1'b0};
    assign ev_off = '{kind: KIND_OFF, note: snote_reg, vel: VEL_NONE, step: head.step,
                      last: 1'b0};
    assign ev_all = '{kind: KIND_ALL_OFF, note: '0, vel: VEL_NONE, step: head.step,
                      last: 1'b0};

    always_comb
    begin
        if (head.clear)
        begin
            n_ev = 2'd0;
        end
        else if (slide_path)
        begin
            n_ev = head.on ? 2'd2 : 2'd1;
        end
        else
        begin
            n_ev = 2'(sounding_reg) + 2'(head.on);
        end
    end

    // slide: new note on (if any) before the old note off; otherwise all off (if sounding) then on
    assign ev_first  = slide_path ? (head.on ? ev_on : ev_off) : (sounding_reg ? ev_all : ev_on);
    assign ev_second = slide_path ? ev_off : ev_on;

    always_comb
    begin
        ev_sel      = ev_idx_reg ? ev_second : ev_first;
        ev_sel.last = (n_ev == 2'd1) || ev_idx_reg;
    end

    assign slot_free = !out_valid_reg || evt.ready;
    assign load      = head_valid && (n_ev != 2'd0) && slot_free;

    always_comb
    begin
        pop           = 1'b0;
        ev_idx_next   = ev_idx_reg;
        sounding_next = sounding_reg;
        snote_next    = snote_reg;
        if (head_valid && (n_ev == 2'd0))
        begin
            pop = 1'b1;
        end
        else if (load)
        begin
            pop         = ev_sel.last;
            ev_idx_next = !ev_sel.last;
        end
        if (pop)
        begin
            if (head.clear)
            begin
                sounding_next = 1'b0;
            end
            else
            begin
                sounding_next = head.on;
                snote_next    = head.on ? head.note : snote_reg;
            end
        end
        out_valid_next = load ? 1'b1 : (evt.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_idx_reg    <= 1'b0;
            sounding_reg  <= 1'b0;
            snote_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ev_idx_reg    <= ev_idx_next;
            sounding_reg  <= sounding_next;
            snote_reg     <= snote_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= ev_sel;
        end
    end

    assign evt.valid       = out_valid_reg;
    assign evt.event_kind  = out_reg.kind;
    assign evt.note_number = out_reg.note;
    assign evt.velocity_q8 = out_reg.vel;
    assign evt.step_now    = out_reg.step;
    assign evt.last        = out_reg.last;

endmodule

### sv/step_sequencer_slide_accent.sv
// top level of the step sequencer with slide and accent
// depends on sqsa_pkg, sqsa_if, sqsa_front, sqsa_queue, sqsa_back, macros header
//
// usage:
//   cmd carries one word per audio sample tick, or a step-table write, start
//   or stop-and-rewind. cfg writes the step length (samples, 8 fraction bits,
//   index 0) and the step count (index 1); write it only while idle.
//   evt gives note on, note off and all-notes-off words; last marks the final
//   word caused by one command.
// throughput: one command per cycle while cmd.ready is high. a step change that
//   gives two events loads the event register twice, one event per cycle while
//   evt.ready is high; the queue lets the front keep taking commands.
// path: the first event of a step change reaches evt through the table read on
//   the accepting edge, the queue and the output register.
// reset: all steps read as empty, playback stopped and rewound, step length
//   6000 samples, 16 steps. no clearing pass is needed.
// stall: when evt.ready is low the event register holds; the queue then
//   fills and cmd.ready drops until the back end moves again.
`timescale 1ns / 1ps
`include "step_sequencer_slide_accent_macros.svh"

module step_sequencer_slide_accent import sqsa_pkg::*; #(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int Q_DEPTH   = Q_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sqsa_cmd_if.sink   cmd,
    sqsa_evt_if.source evt,
    sqsa_cfg_if.sink   cfg
);

    logic    push_valid;
    logic    push_ready;
    q_item_t push_item;
    logic    head_valid;
    q_item_t head;
    logic    pop;

    sqsa_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sqsa_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    sqsa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .evt        (evt)
    );

    // a plain note off always closes a step change
    `SQSA_ASSERT_IMP(a_off_is_last, evt.valid && !evt.last, evt.event_kind != KIND_OFF, "note off not last")
    // only note on carries a velocity
    `SQSA_ASSERT_IMP(a_vel_on_only, evt.valid && (evt.event_kind != KIND_ON), evt.velocity_q8 == VEL_NONE, "velocity on non note-on")
    // a word in the read stage waits for room in the queue
    `SQSA_ASSERT_NXT(a_s1_holds, push_valid && !push_ready, push_valid, "read stage word dropped")

endmodule
